### rtl/mspq_pkg.sv
// shared types, codes and sizes for the min slot priority queue
`default_nettype none

package mspq_pkg;

   localparam int CAPACITY  = 64;
   localparam int COUNT_W   = $clog2(CAPACITY + 1);
   localparam int FLOOR_W   = 8;
   localparam int SPOT_W    = 10;
   localparam int KEY_W     = FLOOR_W + SPOT_W;
   localparam int OCC_W     = 7;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = SPOT_W;

   localparam logic [FLOOR_W-1:0] MAX_FLOORS_RESET      = FLOOR_W'(10);
   localparam logic [SPOT_W-1:0]  SPOTS_PER_FLOOR_RESET = SPOT_W'(20);

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD     = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_TAKE    = 2'd2,
      CMD_PEEK    = 2'd3
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_FLOORS      = 2'd0,
      CSR_SPOTS_PER_FLOOR = 2'd1
   } csr_index_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic             insert;
      logic             remove;
      logic [KEY_W-1:0] new_key;
   } cell_ctrl_type;

   // where a cell sits relative to the fill level
   typedef struct packed {
      logic occupied;
      logic at_count;
   } cell_pos_type;

endpackage

`default_nettype wire

### rtl/mspq_cell.sv
// one cell of the sorted key chain
`default_nettype none

module mspq_cell (
   input  wire                        clock,
   input  wire mspq_pkg::cell_ctrl_type ctrl,
   input  wire mspq_pkg::cell_pos_type  pos,
   input  wire [mspq_pkg::KEY_W-1:0]  left_key,
   input  wire                        left_gt,
   input  wire [mspq_pkg::KEY_W-1:0]  right_key,
   output logic [mspq_pkg::KEY_W-1:0] key_q,
   output logic                       gt
);

   logic [mspq_pkg::KEY_W-1:0] key_ff;
   logic [mspq_pkg::KEY_W-1:0] key_in;

   // held key of an occupied cell is larger than the one being inserted
   assign gt    = pos.occupied && (key_ff > ctrl.new_key);
   assign key_q = key_ff;

   always_comb begin
      key_in = key_ff;
      if (ctrl.insert) begin
         if (left_gt) begin
            key_in = left_key;
         end else if (gt || pos.at_count) begin
            key_in = ctrl.new_key;
         end
      end else if (ctrl.remove) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

`default_nettype wire

### rtl/min_slot_priority_queue.sv
// top level of the min slot priority queue: command stage, cell chain, response register
//
//  channel  dir  handshake            payload
//  req      in   req_valid/req_ready  req_command, req_floor_in, req_spot_in
//  rsp      out  rsp_valid/rsp_ready  rsp_floor_out, rsp_spot_out, rsp_status, rsp_occupancy
//  csr      in   csr_write_en         csr_index, csr_write_data
//
// a command is first registered into the stage, then in the chain step every cell
// compares the key against its own and shifts toward its neighbor in parallel
// a new beat is taken only once the chain step has freed the stage
// a held response stalls the chain step; one further command waits in the stage
// reset clears the fill count and handshake state; no clearing pass over the cells
`default_nettype none

module min_slot_priority_queue (
   input  wire                              clock,
   input  wire                              reset,
   // command channel
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire [mspq_pkg::CMD_W-1:0]        req_command,
   input  wire [mspq_pkg::FLOOR_W-1:0]      req_floor_in,
   input  wire [mspq_pkg::SPOT_W-1:0]       req_spot_in,
   // response channel
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [mspq_pkg::FLOOR_W-1:0]     rsp_floor_out,
   output logic [mspq_pkg::SPOT_W-1:0]      rsp_spot_out,
   output logic [mspq_pkg::STATUS_W-1:0]    rsp_status,
   output logic [mspq_pkg::OCC_W-1:0]       rsp_occupancy,
   // register write port
   input  wire                              csr_write_en,
   input  wire [mspq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [mspq_pkg::CSR_DAT_W-1:0]    csr_write_data
);

   localparam int KW = mspq_pkg::KEY_W;
   localparam int CW = mspq_pkg::COUNT_W;
   localparam int N  = mspq_pkg::CAPACITY;

   // configuration registers
   logic [mspq_pkg::FLOOR_W-1:0] max_floors_ff;
   logic [mspq_pkg::SPOT_W-1:0]  spots_per_floor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_floors_ff      <= mspq_pkg::MAX_FLOORS_RESET;
         spots_per_floor_ff <= mspq_pkg::SPOTS_PER_FLOOR_RESET;
      end else if (csr_write_en) begin
         unique case (mspq_pkg::csr_index_type'(csr_index))
            mspq_pkg::CSR_MAX_FLOORS: begin
               max_floors_ff <= csr_write_data[mspq_pkg::FLOOR_W-1:0];
            end
            mspq_pkg::CSR_SPOTS_PER_FLOOR: begin
               spots_per_floor_ff <= csr_write_data;
            end
            default: begin
               // index past the list: ignored
            end
         endcase
      end
   end

   // command stage
   logic                         busy_ff;
   logic                         busy_in;
   mspq_pkg::command_type        cmd_ff;
   logic [mspq_pkg::FLOOR_W-1:0] floor_ff;
   logic [mspq_pkg::SPOT_W-1:0]  spot_ff;

   // fill level and response register
   logic [CW-1:0]                 count_ff;
   logic [CW-1:0]                 count_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [mspq_pkg::FLOOR_W-1:0]  rsp_floor_ff;
   logic [mspq_pkg::FLOOR_W-1:0]  rsp_floor_in;
   logic [mspq_pkg::SPOT_W-1:0]   rsp_spot_ff;
   logic [mspq_pkg::SPOT_W-1:0]   rsp_spot_in;
   mspq_pkg::status_type          rsp_status_ff;
   mspq_pkg::status_type          rsp_status_in;
   logic [mspq_pkg::OCC_W-1:0]    rsp_occ_ff;
   logic [mspq_pkg::OCC_W-1:0]    rsp_occ_in;

   logic                          req_take;
   logic                          exec;
   logic                          range_bad;
   logic                          full;
   logic                          empty;
   logic                          do_insert;
   logic                          do_remove;

   mspq_pkg::cell_ctrl_type       ctrl;
   logic [KW-1:0]                 cell_key [N];
   logic [N-1:0]                  cell_gt;

   assign req_ready = !busy_ff;
   assign req_take  = req_valid && !busy_ff;
   // chain step happens only when the response register is free or being read
   assign exec      = busy_ff && (!rsp_valid_ff || rsp_ready);

   assign range_bad = (floor_ff > max_floors_ff) || (spot_ff > spots_per_floor_ff);
   assign full      = (count_ff == CW'(N));
   assign empty     = (count_ff == '0);

   always_comb begin
      do_insert     = 1'b0;
      do_remove     = 1'b0;
      rsp_floor_in  = '0;
      rsp_spot_in   = '0;
      rsp_status_in = mspq_pkg::ST_OK;
      unique case (cmd_ff)
         mspq_pkg::CMD_ADD: begin
            if (range_bad) begin
               rsp_status_in = mspq_pkg::ST_RANGE;
            end else if (full) begin
               rsp_status_in = mspq_pkg::ST_FULL;
            end else begin
               do_insert = exec;
            end
         end
         mspq_pkg::CMD_RELEASE: begin
            // release skips the range check
            if (full) begin
               rsp_status_in = mspq_pkg::ST_FULL;
            end else begin
               do_insert = exec;
            end
         end
         mspq_pkg::CMD_TAKE, mspq_pkg::CMD_PEEK: begin
            if (empty) begin
               rsp_status_in = mspq_pkg::ST_EMPTY;
            end else begin
               // lowest key always sits in the head cell
               rsp_floor_in = cell_key[0][KW-1:mspq_pkg::SPOT_W];
               rsp_spot_in  = cell_key[0][mspq_pkg::SPOT_W-1:0];
               do_remove    = exec && (cmd_ff == mspq_pkg::CMD_TAKE);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CW'(1);
      end else if (do_remove) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign rsp_occ_in = mspq_pkg::OCC_W'(count_in);

   always_comb begin
      busy_in = busy_ff;
      if (exec) begin
         busy_in = 1'b0;
      end else if (req_take) begin
         busy_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff   <= mspq_pkg::command_type'(req_command);
         floor_ff <= req_floor_in;
         spot_ff  <= req_spot_in;
      end
      if (exec) begin
         rsp_floor_ff  <= rsp_floor_in;
         rsp_spot_ff   <= rsp_spot_in;
         rsp_status_ff <= rsp_status_in;
         rsp_occ_ff    <= rsp_occ_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_floor_out = rsp_floor_ff;
   assign rsp_spot_out  = rsp_spot_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

   // cell chain, kept sorted ascending from the head
   assign ctrl.insert  = do_insert;
   assign ctrl.remove  = do_remove;
   assign ctrl.new_key = {floor_ff, spot_ff};

   for (genvar i = 0; i < N; i++) begin : g_cell
      mspq_pkg::cell_pos_type pos;
      logic [KW-1:0]          left_key;
      logic                   left_gt;
      logic [KW-1:0]          right_key;

      assign pos.occupied = (CW'(i) < count_ff);
      assign pos.at_count = (CW'(i) == count_ff);

      if (i == 0) begin : g_head
         assign left_key = ctrl.new_key;
         assign left_gt  = 1'b0;
      end else begin : g_body
         assign left_key = cell_key[i-1];
         assign left_gt  = cell_gt[i-1];
      end

      if (i == N - 1) begin : g_tail
         assign right_key = cell_key[i];
      end else begin : g_inner
         assign right_key = cell_key[i+1];
      end

      mspq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .pos       (pos),
         .left_key  (left_key),
         .left_gt   (left_gt),
         .right_key (right_key),
         .key_q     (cell_key[i]),
         .gt        (cell_gt[i])
      );
   end

   // fill level never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(N))
      else $error("fill count beyond capacity");

   // head of the chain stays the minimum
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CW'(2)) |-> (cell_key[0] <= cell_key[1]))
      else $error("chain head out of order");

   // a chain step always leaves a response and frees the stage
   a_exec_resp: assert property (@(posedge clock) disable iff (reset)
      exec |=> (rsp_valid_ff && !busy_ff))
      else $error("chain step without response");

   // an accepted insert grows the fill level by one
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      do_insert |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("insert did not grow fill count");

   // empty status carries a zero slot
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == mspq_pkg::ST_EMPTY)) |->
      ((rsp_floor_ff == '0) && (rsp_spot_ff == '0)))
      else $error("empty response with nonzero slot");

endmodule

`default_nettype wire
